// ----- design/lcg_pkg.sv -----
// Shared widths, codes and reset values for the mod 2^46 LCG with skip-ahead.
package lcg_pkg;

	localparam int SEED_W     = 46;
	localparam int CNT_W      = 31;
	localparam int LONG_SHIFT = 17;
	localparam int LONG_W     = SEED_W + LONG_SHIFT;
	localparam int DIG_W      = 12;
	localparam int NDIG       = (SEED_W + DIG_W - 1) / DIG_W;
	localparam int MCNT_W     = $clog2(NDIG + 1);
	localparam int BSR_W      = NDIG * DIG_W;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	typedef logic [SEED_W-1:0] seed_t;
	typedef logic [CNT_W-1:0]  count_t;

	typedef enum logic {
		OP_DRAW    = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_MULT = 1'b0,
		REG_SEED = 1'b1
	} reg_idx_t;

	localparam seed_t MULT_RESET = 46'd1220703125;
	localparam seed_t SEED_RESET = 46'd314159265;

endpackage

// ----- design/lcg_in_if.sv -----
// Input channel: opcode and step count with valid/ready.
interface lcg_in_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [lcg_pkg::CNT_W-1:0]       step_count;

	modport source (output valid, opcode, step_count, input ready);
	modport sink   (input valid, opcode, step_count, output ready);
endinterface

// ----- design/lcg_out_if.sv -----
// Output channel: drawn number as fraction and long value with valid/ready.
interface lcg_out_if;
	logic                            valid;
	logic                            ready;
	logic [lcg_pkg::SEED_W-1:0]      fraction;
	logic [lcg_pkg::LONG_W-1:0]      long_value;

	modport source (output valid, fraction, long_value, input ready);
	modport sink   (input valid, fraction, long_value, output ready);
endinterface

// ----- design/lcg_mul.sv -----
// Digit-serial multiplier mod 2^46: one 12-bit digit of b per cycle.
module lcg_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lcg_pkg::seed_t a,
	input  lcg_pkg::seed_t b,
	output logic           done,
	output lcg_pkg::seed_t prod
);

	lcg_pkg::seed_t                    a_q;
	logic [lcg_pkg::BSR_W-1:0]         b_q;
	lcg_pkg::seed_t                    acc_q;
	logic [lcg_pkg::MCNT_W-1:0]        cnt_q;
	lcg_pkg::seed_t                    acc_next;

	// partial product is truncated to 46 bits: higher bits vanish mod 2^46
	assign acc_next = acc_q + lcg_pkg::SEED_W'(a_q * b_q[lcg_pkg::DIG_W-1:0]);
	assign done     = (cnt_q == lcg_pkg::MCNT_W'(1));
	assign prod     = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= lcg_pkg::MCNT_W'(lcg_pkg::NDIG);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - lcg_pkg::MCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= lcg_pkg::BSR_W'(b);
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			a_q   <= a_q << lcg_pkg::DIG_W;
			b_q   <= b_q >> lcg_pkg::DIG_W;
			acc_q <= acc_next;
		end
	end

endmodule

// ----- design/lcg_mod_2_46_with_skip_ahead_top.sv -----
// Top level: LCG seed = multiplier * seed mod 2^46 with draw and skip-ahead.
//
// Input channel in_ch carries opcode and step_count; a beat is taken only
// while the block is idle. A draw multiplies the seed once and returns one
// beat on out_ch: fraction = new seed (46 fraction bits), long_value = new
// seed << 17. An advance returns no beat; it applies square-and-multiply over
// the bits of step_count, a count of zero leaves the seed as it is.
// Every multiply runs on a 12-bit digit-serial unit. A draw loads the output
// register as its product completes, unless out_ch stalls, and a new draw is
// taken only after the last one is through. An advance runs one round of
// square-and-multiply per significant bit of step_count (two units run the
// seed and power products together).
// The result sits in an output register; a finished draw waits in a hold
// state while out_ch stalls, and no new input beat is taken until it moves.
// APB port: multiplier at 0x0, initial_seed at 0x8 (64-bit data). Writing
// initial_seed reloads the current seed. Reset restores the default
// multiplier 1220703125 and seed 314159265 and empties the output register.
module lcg_mod_2_46_with_skip_ahead_top (
	input  logic                         clk,
	input  logic                         arst_n,
	lcg_in_if.sink                       in_ch,
	lcg_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lcg_pkg::PADDR_W-1:0]  paddr,
	input  logic [lcg_pkg::PDATA_W-1:0]  pwdata,
	output logic [lcg_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DRAW = 4'b0010,
		ST_ADV  = 4'b0100,
		ST_PUT  = 4'b1000
	} state_t;

	state_t                 state_q;
	lcg_pkg::seed_t         mult_q;
	lcg_pkg::seed_t         init_seed_q;
	lcg_pkg::seed_t         seed_q;
	lcg_pkg::seed_t         pow_q;
	lcg_pkg::count_t        cnt_q;
	logic                   restart_q;
	logic                   out_valid_q;
	lcg_pkg::seed_t         frac_q;

	logic                   in_acc;
	logic                   cfg_wr;
	logic                   out_free;
	logic                   mul_start;
	lcg_pkg::seed_t         op_a;
	logic                   done_a;
	logic                   done_b;
	lcg_pkg::seed_t         prod_a;
	lcg_pkg::seed_t         prod_b;
	logic                   load_out;
	lcg_pkg::seed_t         load_val;

	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite;
	assign prdata       = (paddr[3] == lcg_pkg::REG_SEED) ?
		lcg_pkg::PDATA_W'(init_seed_q) : lcg_pkg::PDATA_W'(mult_q);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign out_free     = !out_valid_q || out_ch.ready;

	// first product of an item uses the multiplier register directly
	assign mul_start    = in_acc || restart_q;
	assign op_a         = (state_q == ST_IDLE) ? mult_q : pow_q;

	lcg_mul u_mul_seed (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (seed_q),
		.done   (done_a),
		.prod   (prod_a)
	);

	lcg_mul u_mul_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_a),
		.done   (done_b),
		.prod   (prod_b)
	);

	always_comb begin
		load_out = 1'b0;
		load_val = prod_a;
		case (state_q)
			ST_DRAW: load_out = done_a && out_free;
			ST_PUT: begin
				load_out = out_free;
				load_val = seed_q;
			end
			default: load_out = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mult_q      <= lcg_pkg::MULT_RESET;
			init_seed_q <= lcg_pkg::SEED_RESET;
			seed_q      <= lcg_pkg::SEED_RESET;
			restart_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// another square-and-multiply round follows while count bits remain
			restart_q <= (state_q == ST_ADV) && done_a &&
				(cnt_q[lcg_pkg::CNT_W-1:1] != '0);

			if (cfg_wr) begin
				if (paddr[3] == lcg_pkg::REG_SEED) begin
					init_seed_q <= pwdata[lcg_pkg::SEED_W-1:0];
					seed_q      <= pwdata[lcg_pkg::SEED_W-1:0];
				end else begin
					mult_q <= pwdata[lcg_pkg::SEED_W-1:0];
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_ch.opcode == lcg_pkg::OP_DRAW) begin
							state_q <= ST_DRAW;
						end else if (in_ch.step_count != '0) begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_DRAW: begin
					if (done_a) begin
						seed_q  <= prod_a;
						state_q <= out_free ? ST_IDLE : ST_PUT;
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ADV: begin
					if (done_a) begin
						if (cnt_q[0]) begin
							seed_q <= prod_a;
						end
						if (cnt_q[lcg_pkg::CNT_W-1:1] == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers: power and count for skip-ahead, output value
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cnt_q <= in_ch.step_count;
		end else if (state_q == ST_ADV && done_a) begin
			pow_q <= prod_b;
			cnt_q <= cnt_q >> 1;
		end
		if (load_out) begin
			frac_q <= load_val;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.fraction   = frac_q;
	assign out_ch.long_value = {frac_q, {lcg_pkg::LONG_SHIFT{1'b0}}};

	// both units are always started together and must finish together
	a_units_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_a == done_b)
		else $error("multiplier units out of step");

	a_restart_in_adv: assert property (@(posedge clk) disable iff (!arst_n)
		restart_q |-> state_q == ST_ADV)
		else $error("restart outside advance");

	a_put_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUT |-> out_valid_q)
		else $error("hold state without pending output");

	a_draw_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_ch.opcode == lcg_pkg::OP_DRAW |=> state_q == ST_DRAW)
		else $error("draw beat did not start a multiply");

endmodule
